/* design/assert_macros.svh */
// Assertion macros included by the ALU core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while the block is out of reset.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every clock edge, during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* design/alu8f_pkg.sv */
package alu8f_pkg;

  localparam int KIND_W = 5;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 3;
  localparam int FLAG_W = 4;

  localparam logic [KIND_W-1:0] KIND_ADD   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_ADC   = 5'd1;
  localparam logic [KIND_W-1:0] KIND_SBC   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_SUB   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_CP    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_INC   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_DEC   = 5'd6;
  localparam logic [KIND_W-1:0] KIND_ADD16 = 5'd7;
  localparam logic [KIND_W-1:0] KIND_RLC   = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RRC   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_RL    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_RR    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_SLA   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_SRA   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_SRL   = 5'd14;
  localparam logic [KIND_W-1:0] KIND_SWAP  = 5'd15;
  localparam logic [KIND_W-1:0] KIND_BIT   = 5'd16;
  localparam logic [KIND_W-1:0] KIND_SET   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_RES   = 5'd18;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
    logic [IDX_W-1:0]  bit_index;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic [FLAG_W-1:0] flags_out;
  } out_word_t;

endpackage

/* design/alu8f_in_if.sv */
interface alu8f_in_if;
  logic               valid;
  logic               ready;
  alu8f_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/alu8f_out_if.sv */
interface alu8f_out_if;
  logic                valid;
  logic                ready;
  alu8f_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/eight_bit_cpu_alu_with_flags_core.sv */
// Eight-bit CPU ALU with a Z, N, H, C flag register. Each input word carries an
// operation, two operands and a bit index, and produces one output word with the result and
// the new flags, in order. A word passes an input register, one stage of arithmetic and an
// output register. An accepted word waits in the input register until the output register is
// free, then its result moves there. One word is taken every cycle while the output is
// drained, and a stalled output holds the input. The flag register is written by that single
// arithmetic stage, which lets each operation see the flags left by the one before it. Reset
// clears the flags.
`include "assert_macros.svh"

module eight_bit_cpu_alu_with_flags_core (
  input  logic      clk,
  input  logic      rst_n,
  alu8f_in_if.sink  in_ch,
  alu8f_out_if.source out_ch
);
  import alu8f_pkg::*;

  in_word_t          s1_r;
  logic              s1_valid_r;
  out_word_t         out_r;
  logic              out_valid_r;
  logic [FLAG_W-1:0] flag_r;
  logic [FLAG_W-1:0] flag_nxt;
  logic [WORD_W-1:0] res_nxt;
  logic              fire;
  logic              in_acc;

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic              cin;
  logic [BYTE_W:0]   add_sum;
  logic [4:0]        add_half;
  logic [BYTE_W:0]   sub_diff;
  logic [4:0]        sub_half;
  logic [WORD_W:0]   add16_sum;
  logic [12:0]       add16_half;
  logic [BYTE_W-1:0] r8;
  logic [BYTE_W-1:0] bit_mask;
  logic              use_cin;

  assign fire         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || fire;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign a        = s1_r.operand_a[BYTE_W-1:0];
  assign b        = s1_r.operand_b[BYTE_W-1:0];
  assign use_cin  = (s1_r.kind == KIND_ADC) || (s1_r.kind == KIND_SBC);
  assign cin      = flag_r[FLAG_C] & use_cin;
  assign bit_mask = BYTE_W'(1) << s1_r.bit_index;

  assign add_sum    = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, cin};
  assign add_half   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
  assign sub_diff   = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, cin};
  assign sub_half   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};
  assign add16_sum  = {1'b0, s1_r.operand_a} + {1'b0, s1_r.operand_b};
  assign add16_half = {1'b0, s1_r.operand_a[11:0]} + {1'b0, s1_r.operand_b[11:0]};

  always_comb begin
    r8       = '0;
    res_nxt  = '0;
    flag_nxt = flag_r;
    unique case (s1_r.kind)
      KIND_ADD, KIND_ADC: begin
        r8 = add_sum[BYTE_W-1:0];
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 1'b0, add_half[4], add_sum[BYTE_W]};
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        r8 = sub_diff[BYTE_W-1:0];
        res_nxt = (s1_r.kind == KIND_CP) ? s1_r.operand_a : {8'b0, r8};
        flag_nxt = {r8 == '0, 1'b1, sub_half[4], sub_diff[BYTE_W]};
      end
      KIND_INC: begin
        r8 = a + 8'd1;
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 1'b0, a[3:0] == 4'hf, flag_r[FLAG_C]};
      end
      KIND_DEC: begin
        r8 = a - 8'd1;
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 1'b1, a[3:0] == 4'h0, flag_r[FLAG_C]};
      end
      KIND_ADD16: begin
        res_nxt = add16_sum[WORD_W-1:0];
        flag_nxt = {flag_r[FLAG_Z], 1'b0, add16_half[12], add16_sum[WORD_W]};
      end
      KIND_RLC: begin
        r8 = {a[6:0], a[7]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[7]};
      end
      KIND_RRC: begin
        r8 = {a[0], a[7:1]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[0]};
      end
      KIND_RL: begin
        r8 = {a[6:0], flag_r[FLAG_C]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[7]};
      end
      KIND_RR: begin
        r8 = {flag_r[FLAG_C], a[7:1]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[0]};
      end
      KIND_SLA: begin
        r8 = {a[6:0], 1'b0};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[7]};
      end
      KIND_SRA: begin
        r8 = {a[7], a[7:1]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[0]};
      end
      KIND_SRL: begin
        r8 = {1'b0, a[7:1]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 2'b00, a[0]};
      end
      KIND_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        res_nxt = {8'b0, r8};
        flag_nxt = {r8 == '0, 3'b000};
      end
      KIND_BIT: begin
        res_nxt = s1_r.operand_a;
        flag_nxt = {(a & bit_mask) == '0, 2'b01, flag_r[FLAG_C]};
      end
      KIND_SET: begin
        r8 = a | bit_mask;
        res_nxt = {8'b0, r8};
      end
      KIND_RES: begin
        r8 = a & ~bit_mask;
        res_nxt = {8'b0, r8};
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flag_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        flag_r      <= flag_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_ch.data;
    end
    if (fire) begin
      out_r.result    <= res_nxt;
      out_r.flags_out <= flag_nxt;
    end
  end

  // The flag register moves only when a word passes the arithmetic stage.
  `ASSERT_RST(a_flags_hold, clk, rst_n, !fire |=> $stable(flag_r))
  // A word in the output register always reports the flags now held.
  `ASSERT_RST(a_out_flags, clk, rst_n, out_valid_r |-> (out_r.flags_out == flag_r))
  // An accepted word is always waiting in the input register next cycle.
  `ASSERT_RST(a_in_taken, clk, rst_n, in_acc |=> s1_valid_r)
  // Every word leaving the arithmetic stage lands in the output register.
  `ASSERT_RST(a_fire_out, clk, rst_n, fire |=> out_valid_r)

endmodule
